@@ src/bba_pkg.sv @@
// bba_pkg: shared types and constants of the buddy block allocator
// no dependencies; imported by buddy_block_allocator

package bba_pkg;

  localparam int DEF_POOL_LOG2 = 16;
  localparam int MIN_ORDER     = 4;
  localparam int HDR_BYTES     = 8;
  localparam int CFG_W         = 17;
  localparam logic [CFG_W-1:0] POOL_RESET = 17'd65536;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } bba_req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] address;
  } bba_rsp_t;

  // block table entry: free flag and order minus 3
  function automatic logic [5:0] bba_entry(input logic [4:0] order, input logic is_free);
    logic [4:0] code;
    code = order - 5'd3;
    return {is_free, code};
  endfunction

endpackage

@@ src/buddy_block_allocator.sv @@
// buddy_block_allocator: buddy allocator with block table memory and a small sequencer
// depends on bba_pkg

// channel   | direction | handshake          | payload
// in        | input     | in_valid/in_stall  | in_req (mode, request_bytes, release_address)
// out       | output    | out_valid/out_stall| out_rsp (status, address)
// cfg       | input     | cfg_wr_en          | cfg_wr_data (pool_bytes)
//
// one request at a time; the block table memory (one read and one write port) sets the time
// acquire: sizing, a search for the smallest order with a free block, slot probes, splits, result
// release: table lookup, merging with free buddies order by order, then the freed block is written
// after reset or a cfg write all 2^(POOL_LOG2-4) table entries are cleared, then the pool is
// carved order by order from POOL_LOG2 down to MIN_ORDER; no request is taken meanwhile
// the result sits in an output register, so a stalled result does not block the next request

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int POOL_LOG2 = DEF_POOL_LOG2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bba_req_t         in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output bba_rsp_t         out_rsp,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int GW     = POOL_LOG2 - MIN_ORDER;        // granule index bits
  localparam int GRAN   = 1 << GW;
  localparam int ORDERS = POOL_LOG2 - MIN_ORDER + 1;
  localparam int OW     = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int CNTW   = GW + 1;
  localparam int CW     = (POOL_LOG2 + 1 > CFG_W) ? POOL_LOG2 + 1 : CFG_W;
  localparam logic [4:0] PL  = 5'(POOL_LOG2);
  localparam logic [4:0] MO  = 5'(MIN_ORDER);

  // sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_CARVE   = 4'd1;
  localparam logic [3:0] S_IDLE    = 4'd2;
  localparam logic [3:0] S_SIZE    = 4'd3;
  localparam logic [3:0] S_FIND    = 4'd4;
  localparam logic [3:0] S_PRB_RD  = 4'd5;
  localparam logic [3:0] S_PRB_CMP = 4'd6;
  localparam logic [3:0] S_SPLIT   = 4'd7;
  localparam logic [3:0] S_REL_RD  = 4'd8;
  localparam logic [3:0] S_REL_CHK = 4'd9;
  localparam logic [3:0] S_MRG_RD  = 4'd10;
  localparam logic [3:0] S_MRG_CMP = 4'd11;
  localparam logic [3:0] S_REL_END = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  // counter operations
  localparam logic [1:0] C_NONE = 2'd0;
  localparam logic [1:0] C_INC  = 2'd1;
  localparam logic [1:0] C_DEC  = 2'd2;
  localparam logic [1:0] C_SET1 = 2'd3;

  // saturate and round the pool size
  function automatic logic [POOL_LOG2:0] carve_size(input logic [CFG_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w < CW'(16)) w = CW'(16);
    if (w > (CW'(1) << POOL_LOG2)) w = CW'(1) << POOL_LOG2;
    w[3:0] = 4'd0;
    return w[POOL_LOG2:0];
  endfunction

  function automatic logic [OW-1:0] oidx(input logic [4:0] order);
    logic [4:0] d;
    d = order - MO;
    return d[OW-1:0];
  endfunction

  // block table memory
  logic [5:0]    mem [GRAN];
  logic          mem_we;
  logic [GW-1:0] mem_wa, mem_ra;
  logic [5:0]    mem_wd, rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  // free block counts per order
  logic [CNTW-1:0] cnt_r [ORDERS];
  logic [1:0]      cnt_op;
  logic            cnt_clr;
  logic [OW-1:0]   cnt_idx;

  always_ff @(posedge clk) begin
    if (cnt_clr) begin
      for (int q = 0; q < ORDERS; q++) cnt_r[q] <= '0;
    end else begin
      case (cnt_op)
        C_INC:   cnt_r[cnt_idx] <= cnt_r[cnt_idx] + CNTW'(1);
        C_DEC:   cnt_r[cnt_idx] <= cnt_r[cnt_idx] - CNTW'(1);
        C_SET1:  cnt_r[cnt_idx] <= CNTW'(1);
        default: ;
      endcase
    end
  end

  logic [3:0]          state_r, state_nxt;
  logic [GW-1:0]       clr_r, clr_nxt;
  logic [4:0]          bo_r, bo_nxt;
  logic [POOL_LOG2:0]  off_r, off_nxt;
  logic [POOL_LOG2:0]  carved_r, carved_nxt;
  logic [16:0]         n_r, n_nxt;
  logic [4:0]          ord_r, ord_nxt;
  logic [4:0]          j_r, j_nxt;
  logic [4:0]          m_r, m_nxt;
  logic [4:0]          k_r, k_nxt;
  logic [GW:0]         i_r, i_nxt;
  logic [POOL_LOG2-1:0] ro_r, ro_nxt;
  logic                res_st_r, res_st_nxt;
  logic [15:0]         res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  bba_rsp_t            out_rsp_r, out_rsp_nxt;

  // helper values
  logic [15:0]         rel_o;
  logic [CW-1:0]       rel_ow;
  logic [5:0]          e_k;
  logic [POOL_LOG2:0]  root_x;
  logic [5:0]          k_p1;
  logic [4:0]          half;
  logic [GW-1:0]       bud;
  logic [POOL_LOG2-1:0] bro;
  logic [31:0]         acq_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    bo_nxt        = bo_r;
    off_nxt       = off_r;
    carved_nxt    = carved_r;
    n_nxt         = n_r;
    ord_nxt       = ord_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    ro_nxt        = ro_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_ra        = '0;
    cnt_op        = C_NONE;
    cnt_clr       = 1'b0;
    cnt_idx       = '0;

    rel_o    = in_req.release_address - 16'(HDR_BYTES);
    rel_ow   = CW'(rel_o);
    e_k      = {1'b0, rd_data_r[4:0]} + 6'd3;
    root_x   = {1'b0, ro_r} ^ carved_r;
    k_p1     = {1'b0, k_r} + 6'd1;
    half     = m_r - 5'd1;
    bud      = i_r[GW-1:0] + (GW'(1) << (half - MO));
    bro      = ro_r ^ (POOL_LOG2'(1) << k_r);
    acq_addr = (32'(i_r) << 4) + 32'(HDR_BYTES);

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        cnt_clr = 1'b1;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == {GW{1'b1}}) begin
          state_nxt = S_CARVE;
          bo_nxt    = PL;
          off_nxt   = '0;
        end
      end
      S_CARVE: begin
        if (carved_r[bo_r]) begin
          mem_we  = 1'b1;
          mem_wa  = off_r[POOL_LOG2-1:MIN_ORDER];
          mem_wd  = bba_entry(bo_r, 1'b1);
          cnt_op  = C_SET1;
          cnt_idx = oidx(bo_r);
          off_nxt = off_r + ((POOL_LOG2+1)'(1) << bo_r);
        end
        bo_nxt = bo_r - 5'd1;
        if (bo_r == MO) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_req.mode == MODE_ACQUIRE) begin
            n_nxt     = 17'(in_req.request_bytes) + 17'(HDR_BYTES);
            ord_nxt   = MO;
            state_nxt = S_SIZE;
          end else begin
            res_st_nxt   = STATUS_DONE;
            res_addr_nxt = '0;
            ro_nxt       = rel_ow[POOL_LOG2-1:0];
            if (in_req.release_address < 16'(HDR_BYTES) || rel_o[3:0] != 4'd0 ||
                rel_ow >= CW'(carved_r)) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_REL_RD;
            end
          end
        end
      end
      // bit length of the padded size, at least MIN_ORDER, one bit a cycle
      S_SIZE: begin
        if ((n_r >> ord_r) != 17'd0) begin
          ord_nxt = ord_r + 5'd1;
        end else if (ord_r > PL) begin
          res_st_nxt   = STATUS_NO_SPACE;
          res_addr_nxt = '0;
          state_nxt    = S_OUT;
        end else begin
          j_nxt     = ord_r;
          state_nxt = S_FIND;
        end
      end
      // smallest order with a free block
      S_FIND: begin
        cnt_idx = oidx(j_r);
        if (j_r > PL) begin
          res_st_nxt   = STATUS_NO_SPACE;
          res_addr_nxt = '0;
          state_nxt    = S_OUT;
        end else if (cnt_r[cnt_idx] != '0) begin
          i_nxt     = '0;
          state_nxt = S_PRB_RD;
        end else begin
          j_nxt = j_r + 5'd1;
        end
      end
      S_PRB_RD: begin
        mem_ra = i_r[GW-1:0];
        if (i_r >= carved_r[POOL_LOG2:MIN_ORDER]) begin
          res_st_nxt   = STATUS_NO_SPACE;
          res_addr_nxt = '0;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_PRB_CMP;
        end
      end
      S_PRB_CMP: begin
        if (rd_data_r == bba_entry(j_r, 1'b1)) begin
          cnt_op    = C_DEC;
          cnt_idx   = oidx(j_r);
          m_nxt     = j_r;
          state_nxt = S_SPLIT;
        end else begin
          i_nxt     = i_r + ((GW+1)'(1) << (j_r - MO));
          state_nxt = S_PRB_RD;
        end
      end
      // split down one order a cycle, upper halves go free
      S_SPLIT: begin
        mem_we = 1'b1;
        if (m_r > ord_r) begin
          mem_wa  = bud;
          mem_wd  = bba_entry(half, 1'b1);
          cnt_op  = C_INC;
          cnt_idx = oidx(half);
          m_nxt   = half;
        end else begin
          mem_wa       = i_r[GW-1:0];
          mem_wd       = bba_entry(ord_r, 1'b0);
          res_st_nxt   = STATUS_DONE;
          res_addr_nxt = acq_addr[15:0];
          state_nxt    = S_OUT;
        end
      end
      S_REL_RD: begin
        mem_ra    = ro_r[POOL_LOG2-1:MIN_ORDER];
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (rd_data_r[4:0] == 5'd0 || rd_data_r[5] || e_k > {1'b0, PL}) begin
          state_nxt = S_OUT;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = ro_r[POOL_LOG2-1:MIN_ORDER];
          k_nxt     = e_k[4:0];
          state_nxt = S_MRG_RD;
        end
      end
      // merge with the buddy while it is free and inside the root block
      S_MRG_RD: begin
        mem_ra = bro[POOL_LOG2-1:MIN_ORDER];
        if (k_r < PL && (root_x >> k_p1) != '0) begin
          state_nxt = S_MRG_CMP;
        end else begin
          state_nxt = S_REL_END;
        end
      end
      S_MRG_CMP: begin
        if (rd_data_r == bba_entry(k_r, 1'b1)) begin
          mem_we    = 1'b1;
          mem_wa    = bro[POOL_LOG2-1:MIN_ORDER];
          cnt_op    = C_DEC;
          cnt_idx   = oidx(k_r);
          ro_nxt    = ro_r & ~(POOL_LOG2'(1) << k_r);
          k_nxt     = k_r + 5'd1;
          state_nxt = S_MRG_RD;
        end else begin
          state_nxt = S_REL_END;
        end
      end
      S_REL_END: begin
        mem_we    = 1'b1;
        mem_wa    = ro_r[POOL_LOG2-1:MIN_ORDER];
        mem_wd    = bba_entry(k_r, 1'b1);
        cnt_op    = C_INC;
        cnt_idx   = oidx(k_r);
        state_nxt = S_OUT;
      end
      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_rsp_nxt.status  = res_st_r;
          out_rsp_nxt.address = res_addr_r;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    // a cfg write re-carves the pool
    if (cfg_wr_en) begin
      carved_nxt = carve_size(cfg_wr_data);
      clr_nxt    = '0;
      state_nxt  = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      carved_r    <= carve_size(POOL_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      carved_r    <= carved_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bo_r       <= bo_nxt;
    off_r      <= off_nxt;
    n_r        <= n_nxt;
    ord_r      <= ord_nxt;
    j_r        <= j_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    ro_r       <= ro_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

endmodule

@@ tb/buddy_block_allocator_tb.sv @@
// buddy_block_allocator_tb: self-checking testbench for the buddy block allocator
// depends on bba_pkg and buddy_block_allocator; a built-in predictor tracks the block
// table and checks every response in order
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int PLOG     = 16;
  localparam int GRAN     = 1 << (PLOG - MIN_ORDER);
  localparam int NORD     = PLOG - MIN_ORDER + 1;
  localparam int DOG_MAX  = 60000;

  // how the release address of a queued request is chosen when it is presented
  typedef enum logic [1:0] {PICK_FIXED, PICK_LIVE, PICK_LAST_FREED} pick_e;

  typedef struct {
    bba_req_t req;
    pick_e    pick;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  bba_req_t         in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  bba_rsp_t         out_rsp;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  buddy_block_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: one entry per 16-byte granule, {free, order-3}
  logic [5:0]  blk_tbl [GRAN];
  int unsigned free_cnt [NORD];
  int unsigned carved_bytes;

  pending_t    pend_q[$];
  bba_rsp_t    rsp_q[$];
  logic [15:0] live_q[$];     // addresses currently held by acquires
  logic [15:0] last_freed = 16'd0;
  int          n_taken = 0;
  int          n_fail = 0;
  bit          took_req = 1'b0;
  bit          calm = 1'b0;     // no idling on either side while set
  int          dog = 0;

  function automatic logic [5:0] tbl_entry(int unsigned order, bit is_free);
    logic [4:0] code;
    code = 5'(order - 3);
    return {is_free, code};
  endfunction

  // carve the pool greedily into power-of-two root blocks, largest first
  function automatic void carve_pool(logic [CFG_W-1:0] bytes);
    int unsigned v;
    int unsigned off;
    v = bytes;
    if (v < 16) v = 16;
    if (v > (1 << PLOG)) v = 1 << PLOG;
    carved_bytes = v & ~32'd15;
    foreach (blk_tbl[i]) blk_tbl[i] = '0;
    foreach (free_cnt[i]) free_cnt[i] = 0;
    off = 0;
    for (int b = PLOG; b >= MIN_ORDER; b--) begin
      if ((carved_bytes >> b) & 1) begin
        blk_tbl[(off >> 4) % GRAN] = tbl_entry(b, 1'b1);
        free_cnt[b - MIN_ORDER]++;
        off += 1 << b;
      end
    end
    live_q.delete();
  endfunction

  // order of the root block holding offset o
  function automatic int unsigned root_of(int unsigned o);
    int unsigned x;
    x = o ^ carved_bytes;
    for (int b = PLOG; b > 0; b--)
      if ((x >> b) & 1) return b;
    return 0;
  endfunction

  function automatic bba_rsp_t predict_acquire(logic [15:0] req_bytes);
    bba_rsp_t    r;
    int unsigned n;
    int unsigned order;
    int unsigned j;
    int unsigned slot;
    int unsigned stride;
    bit          hit;
    r.status  = STATUS_NO_SPACE;
    r.address = '0;
    n = req_bytes + HDR_BYTES;
    order = $clog2(n + 1);    // bit length of n
    if (order < MIN_ORDER) order = MIN_ORDER;
    if (order > PLOG) return r;
    j = order;
    while (j <= PLOG && free_cnt[j - MIN_ORDER] == 0) j++;
    if (j > PLOG) return r;
    stride = 1 << (j - MIN_ORDER);
    hit = 1'b0;
    for (slot = 0; slot < (carved_bytes >> 4); slot += stride)
      if (blk_tbl[slot % GRAN] == tbl_entry(j, 1'b1)) begin
        hit = 1'b1;
        break;
      end
    if (!hit) return r;
    free_cnt[j - MIN_ORDER]--;
    // split down, keeping the lower half each time
    for (int unsigned m = j; m > order; m--) begin
      blk_tbl[(slot + (1 << (m - 1 - MIN_ORDER))) % GRAN] = tbl_entry(m - 1, 1'b1);
      free_cnt[m - 1 - MIN_ORDER]++;
    end
    blk_tbl[slot % GRAN] = tbl_entry(order, 1'b0);
    r.status  = STATUS_DONE;
    r.address = 16'((slot << 4) + HDR_BYTES);
    live_q.push_back(r.address);
    return r;
  endfunction

  function automatic void predict_release(logic [15:0] addr);
    int unsigned o;
    int unsigned k;
    int unsigned bud;
    logic [5:0]  e;
    if (addr < HDR_BYTES) return;
    o = addr - HDR_BYTES;
    if ((o & 15) != 0 || o >= carved_bytes) return;
    e = blk_tbl[(o >> 4) % GRAN];
    if (e[4:0] == 0 || e[5]) return;
    k = e[4:0] + 3;
    if (k < MIN_ORDER || k > PLOG) return;
    foreach (live_q[i])
      if (live_q[i] == addr) begin
        live_q.delete(i);
        break;
      end
    last_freed = addr;
    blk_tbl[(o >> 4) % GRAN] = '0;
    // merge with free buddies, never past the root block
    while (k < PLOG && k + 1 <= root_of(o)) begin
      bud = o ^ (1 << k);
      if (blk_tbl[(bud >> 4) % GRAN] != tbl_entry(k, 1'b1)) break;
      blk_tbl[(bud >> 4) % GRAN] = '0;
      free_cnt[k - MIN_ORDER]--;
      o &= ~(1 << k);
      k++;
    end
    blk_tbl[(o >> 4) % GRAN] = tbl_entry(k, 1'b1);
    free_cnt[k - MIN_ORDER]++;
  endfunction

  // request side: accept, predict, and record the expected response
  always @(posedge clk) begin
    took_req = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        bba_rsp_t r;
        took_req = 1'b1;
        n_taken++;
        if (in_req.mode == MODE_ACQUIRE) begin
          r = predict_acquire(in_req.request_bytes);
        end else begin
          predict_release(in_req.release_address);
          r = '0;   // release always answers done, address 0
        end
        rsp_q.push_back(r);
      end
      // response side: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (rsp_q.size() == 0) begin
          $error("response with nothing expected: status %0d address %0h",
                 out_rsp.status, out_rsp.address);
          n_fail++;
        end else begin
          bba_rsp_t x;
          x = rsp_q.pop_front();
          if (out_rsp.status !== x.status) begin
            $error("status: expected %0d actual %0d", x.status, out_rsp.status);
            n_fail++;
          end
          if (out_rsp.address !== x.address) begin
            $error("address: expected %0h actual %0h", x.address, out_rsp.address);
            n_fail++;
          end
        end
      end
      // watchdog on cycles where neither side moves
      if (took_req || (out_valid && !out_stall)) dog = 0;
      else dog++;
      if (dog >= DOG_MAX) begin
        $display("buddy_block_allocator_tb failed");
        $finish;
      end
    end
  end

  // driver: random out_stall; hold a stalled request, otherwise maybe idle, otherwise present the next one
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= !calm && ($urandom_range(99) < 24);
      if (!(in_valid && !took_req)) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          pending_t p;
          bba_req_t q;
          p = pend_q.pop_front();
          q = p.req;
          if (p.pick == PICK_LIVE && live_q.size() != 0)
            q.release_address = live_q[$urandom_range(live_q.size() - 1)];
          else if (p.pick == PICK_LAST_FREED)
            q.release_address = last_freed;
          in_req   <= q;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_req(logic mode, logic [15:0] nbytes, logic [15:0] addr, pick_e pick);
    pending_t p;
    p.req.mode            = mode;
    p.req.request_bytes   = nbytes;
    p.req.release_address = addr;
    p.pick                = pick;
    pend_q.push_back(p);
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_valid || rsp_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // new pool size: block must be idle; predictor re-carves at the same time
  task automatic set_pool(logic [CFG_W-1:0] bytes);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bytes;
    carve_pool(bytes);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic gen_random(int count);
    int          r;
    logic [15:0] sz;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        case ($urandom_range(9))
          0:       sz = 16'($urandom());
          1, 2:    sz = 16'($urandom_range(2000));
          default: sz = 16'($urandom_range(120));
        endcase
        push_req(MODE_ACQUIRE, sz, 16'($urandom()), PICK_FIXED);
      end else if (r < 85) begin
        push_req(MODE_RELEASE, 16'($urandom()), 16'($urandom()), PICK_LIVE);
      end else if (r < 93) begin
        // garbage: half aligned granule addresses, half fully random
        sz = ($urandom_range(1)) ? 16'(($urandom_range(GRAN - 1) << 4) + HDR_BYTES)
                                 : 16'($urandom());
        push_req(MODE_RELEASE, 16'($urandom()), sz, PICK_FIXED);
      end else begin
        push_req(MODE_RELEASE, 16'($urandom()), 16'd0, PICK_LAST_FREED);  // double free
      end
    end
  endtask

  initial begin
    carve_pool(POOL_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, order boundaries, bad releases, double release
    push_req(MODE_ACQUIRE, 16'd0,     16'hFFFF, PICK_FIXED);
    push_req(MODE_ACQUIRE, 16'd7,     16'h0000, PICK_FIXED);
    push_req(MODE_ACQUIRE, 16'd8,     16'h0000, PICK_FIXED);
    push_req(MODE_ACQUIRE, 16'd65535, 16'h0000, PICK_FIXED);  // order above pool
    push_req(MODE_ACQUIRE, 16'd65528, 16'h0000, PICK_FIXED);  // exactly 2^16 with header
    push_req(MODE_ACQUIRE, 16'd32760, 16'h0000, PICK_FIXED);  // half pool
    push_req(MODE_ACQUIRE, 16'd32760, 16'h0000, PICK_FIXED);  // no block left that big
    push_req(MODE_RELEASE, 16'hFFFF,  16'd0,    PICK_FIXED);  // below header
    push_req(MODE_RELEASE, 16'd0,     16'd7,    PICK_FIXED);
    push_req(MODE_RELEASE, 16'd0,     16'd9,    PICK_FIXED);  // misaligned
    push_req(MODE_RELEASE, 16'd0,     16'hFFFF, PICK_FIXED);
    push_req(MODE_RELEASE, 16'd0,     16'd24,   PICK_FIXED);  // start of the second acquired block
    push_req(MODE_RELEASE, 16'd0,     16'd0,    PICK_LIVE);
    push_req(MODE_RELEASE, 16'd0,     16'd0,    PICK_LAST_FREED);
    push_req(MODE_RELEASE, 16'd0,     16'd0,    PICK_LIVE);
    push_req(MODE_RELEASE, 16'd0,     16'd0,    PICK_LIVE);
    push_req(MODE_RELEASE, 16'd0,     16'd0,    PICK_LIVE);
    push_req(MODE_ACQUIRE, 16'd65520, 16'h0000, PICK_FIXED);  // whole pool once all merged
    push_req(MODE_RELEASE, 16'd0,     16'd8,    PICK_FIXED);
    gen_random(180);
    // quiet stretch with no idling on either side
    wait_drained();
    calm = 1'b1;
    gen_random(150);
    wait_drained();
    calm = 1'b0;
    gen_random(170);

    // smallest pool: a single 16-byte block
    set_pool(17'd0);
    push_req(MODE_ACQUIRE, 16'd0, 16'd0, PICK_FIXED);
    push_req(MODE_ACQUIRE, 16'd0, 16'd0, PICK_FIXED);
    push_req(MODE_RELEASE, 16'd0, 16'd8, PICK_FIXED);
    push_req(MODE_ACQUIRE, 16'd8, 16'd0, PICK_FIXED);
    gen_random(40);

    // largest register value saturates to the full pool
    set_pool(17'h1FFFF);
    gen_random(150);

    // odd sizes give several roots that never merge together
    set_pool(17'd1000);
    gen_random(120);
    set_pool(17'd65535);
    gen_random(80);
    for (int i = 0; i < 3; i++) begin
      set_pool(17'($urandom_range(16, 131071)));
      gen_random(60);
    end
    set_pool(17'd16);
    gen_random(20);

    wait_drained();
    if (n_fail == 0) begin
      $display("buddy_block_allocator_tb passed");
    end else begin
      $display("buddy_block_allocator_tb failed");
    end
    $finish;
  end

endmodule
